// ===== design/pns_pkg.sv =====
// Package for the periodic notification scheduler.
// Holds the entry and control types, operation codes and the key compare.
// Used by pns_cell, pns_out_buf and periodic_notification_scheduler.
package pns_pkg;

    localparam int MAX_CLIENTS_DEF = 64;
    // Registration order is kept in a fixed field wide enough for the
    // largest supported table of 1024 clients.
    localparam int SEQ_W = 10;
    localparam int ID_W = 16;
    localparam int PER_W = 16;
    localparam int DUE_W = 32;
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_STEP  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP_INSERT,
        OP_CLEAR
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_INSERT
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [DUE_W-1:0] due;
        logic [ID_W-1:0]  id;
        logic [SEQ_W-1:0] seq;
        logic [PER_W-1:0] per;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   ins;
    } cell_ctrl_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DUE_W-1:0] due;
        logic             empty;
    } result_t;

    // Ordering of the table: earlier due time first, then smaller id, then
    // earlier registration.
    function automatic logic key_less(entry_t a, entry_t b);
        return {a.due, a.id, a.seq} < {b.due, b.id, b.seq};
    endfunction

endpackage

// ===== design/pns_cell.sv =====
// One cell of the sorted entry chain of the notification scheduler.
// Depends on pns_pkg for the entry and control types.
module pns_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  pns_pkg::cell_ctrl_t ctrl,
    input  logic               head,
    input  pns_pkg::entry_t    left_q,
    input  logic               left_lt,
    input  pns_pkg::entry_t    right_q,
    input  logic               right_lt,
    output pns_pkg::entry_t    q,
    output logic               lt
);

    pns_pkg::entry_t entry_reg;
    pns_pkg::entry_t entry_next;

    // This entry sorts ahead of the entry being inserted.
    assign lt = entry_reg.valid && pns_pkg::key_less(entry_reg, ctrl.ins);
    assign q  = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (ctrl.op)
            pns_pkg::OP_INSERT: begin
                if (lt) begin
                    entry_next = entry_reg;
                end else if (left_lt) begin
                    entry_next = ctrl.ins;
                end else begin
                    entry_next = left_q;
                end
            end
            pns_pkg::OP_POP_INSERT: begin
                // The head leaves; everything ahead of the new entry moves
                // one place toward the head.
                if (right_lt) begin
                    entry_next = right_q;
                end else if (head || lt) begin
                    entry_next = ctrl.ins;
                end else begin
                    entry_next = entry_reg;
                end
            end
            pns_pkg::OP_CLEAR: begin
                entry_next.valid = 1'b0;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
        entry_reg.due <= entry_next.due;
        entry_reg.id  <= entry_next.id;
        entry_reg.seq <= entry_next.seq;
        entry_reg.per <= entry_next.per;
    end

endmodule

// ===== design/pns_out_buf.sv =====
// Two-entry result buffer (output register plus skid stage).
// Depends on pns_pkg for the result type.
module pns_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pns_pkg::result_t push_data,
    output logic             full,
    output logic             m_valid,
    input  logic             m_ready,
    output pns_pkg::result_t m_data
);

    logic             out_valid_reg;
    logic             out_valid_next;
    pns_pkg::result_t out_data_reg;
    pns_pkg::result_t out_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    pns_pkg::result_t skid_data_reg;
    pns_pkg::result_t skid_data_next;
    logic             pop;

    assign pop     = out_valid_reg && m_ready;
    assign full    = skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");

    a_stall_holds_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_ready |=> skid_valid_reg)
        else $error("skid entry lost while the output was stalled");

endmodule

// ===== design/periodic_notification_scheduler.sv =====
// Periodic notification scheduler: top level, stream ports and control.
// Depends on pns_pkg, pns_cell (sorted entry chain) and pns_out_buf.
//
// The block keeps up to MAX_CLIENTS clients in a chain of cells sorted by
// due time, then client id, then registration order, so the next client to
// notify always sits in the first cell. A load transfer (kind 0) registers a
// client whose first due time is its period; a step transfer (kind 1) emits
// the head client and its due time, then reinserts it with the due time
// advanced by its period and held at the maximum value on overflow; a clear
// transfer (kind 2) empties the table. Loads into a full table
// and kind 3 are dropped without a result, and a step on an empty table
// returns one result with table_empty set and the other fields zero. Loads
// and steps on a non-empty table go through the transfer, in which the step
// result is captured from the head cell, and then the insert state, in which
// every cell compares itself with the new entry and shifts toward or away
// from the head in parallel. Clears, dropped items and steps on an empty
// table stay in the idle state. The result side has an output register
// and a skid stage, so input transfers keep flowing while one result waits;
// s_tready drops only in the insert state or when both result slots are
// full. There is no clearing pass after reset.
module periodic_notification_scheduler #(
    parameter int MAX_CLIENTS = pns_pkg::MAX_CLIENTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] client_id, [31:16] period
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] notified_id, [47:16] due_time
    output logic [0:0]  m_tuser    // [0] table_empty
);

    localparam int CNT_W = $clog2(MAX_CLIENTS + 1);

    pns_pkg::state_t   state_reg;
    pns_pkg::state_t   state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    pns_pkg::entry_t   ins_reg;
    pns_pkg::entry_t   ins_next;
    logic              ins_pop_reg;
    logic              ins_pop_next;

    pns_pkg::cell_ctrl_t cell_ctrl;
    pns_pkg::entry_t     cell_q  [MAX_CLIENTS];
    logic                cell_lt [MAX_CLIENTS];

    logic              s_xfer;
    logic              buf_full;
    logic              res_push;
    pns_pkg::result_t  res_data;
    pns_pkg::result_t  out_data;
    pns_pkg::kind_t    kind;
    logic [pns_pkg::ID_W-1:0]  in_id;
    logic [pns_pkg::PER_W-1:0] in_per;
    logic [pns_pkg::DUE_W:0]   due_sum;
    logic [pns_pkg::DUE_W-1:0] due_adv;

    assign kind   = pns_pkg::kind_t'(s_tuser);
    assign in_id  = s_tdata[15:0];
    assign in_per = s_tdata[31:16];

    assign s_tready = (state_reg == pns_pkg::ST_IDLE) && !buf_full;
    assign s_xfer   = s_tvalid && s_tready;

    // Next due time of the head client, held at the maximum on overflow.
    assign due_sum = {1'b0, cell_q[0].due} + {{(pns_pkg::DUE_W + 1 - pns_pkg::PER_W){1'b0}},
                     cell_q[0].per};
    assign due_adv = due_sum[pns_pkg::DUE_W] ? {pns_pkg::DUE_W{1'b1}}
                                             : due_sum[pns_pkg::DUE_W-1:0];

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ins_next      = ins_reg;
        ins_pop_next  = ins_pop_reg;
        res_push      = 1'b0;
        res_data      = '0;
        cell_ctrl.op  = pns_pkg::OP_HOLD;
        cell_ctrl.ins = ins_reg;
        case (state_reg)
            pns_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    case (kind)
                        pns_pkg::KIND_LOAD: begin
                            if (count_reg < CNT_W'(MAX_CLIENTS)) begin
                                ins_next.valid = 1'b1;
                                ins_next.due   = {{(pns_pkg::DUE_W - pns_pkg::PER_W){1'b0}},
                                                  in_per};
                                ins_next.id    = in_id;
                                ins_next.seq   = pns_pkg::SEQ_W'(count_reg);
                                ins_next.per   = in_per;
                                ins_pop_next   = 1'b0;
                                count_next     = count_reg + CNT_W'(1);
                                state_next     = pns_pkg::ST_INSERT;
                            end
                        end
                        pns_pkg::KIND_STEP: begin
                            res_push = 1'b1;
                            if (count_reg == '0) begin
                                res_data.empty = 1'b1;
                            end else begin
                                res_data.id  = cell_q[0].id;
                                res_data.due = cell_q[0].due;
                                ins_next     = cell_q[0];
                                ins_next.due = due_adv;
                                ins_pop_next = 1'b1;
                                state_next   = pns_pkg::ST_INSERT;
                            end
                        end
                        pns_pkg::KIND_CLEAR: begin
                            cell_ctrl.op = pns_pkg::OP_CLEAR;
                            count_next   = '0;
                        end
                        default: begin
                            state_next = pns_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            pns_pkg::ST_INSERT: begin
                cell_ctrl.op = ins_pop_reg ? pns_pkg::OP_POP_INSERT : pns_pkg::OP_INSERT;
                state_next   = pns_pkg::ST_IDLE;
            end
            default: begin
                state_next = pns_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pns_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        ins_reg     <= ins_next;
        ins_pop_reg <= ins_pop_next;
    end

    // Sorted chain: the first cell sees a virtual left neighbor that sorts
    // ahead of everything, the last one an empty right neighbor.
    for (genvar i = 0; i < MAX_CLIENTS; i++) begin : g_cell
        pns_pkg::entry_t left_q;
        logic            left_lt;
        pns_pkg::entry_t right_q;
        logic            right_lt;

        if (i == 0) begin : g_first
            assign left_q  = '0;
            assign left_lt = 1'b1;
        end else begin : g_mid_left
            assign left_q  = cell_q[i-1];
            assign left_lt = cell_lt[i-1];
        end

        if (i == MAX_CLIENTS - 1) begin : g_last
            assign right_q  = '0;
            assign right_lt = 1'b0;
        end else begin : g_mid_right
            assign right_q  = cell_q[i+1];
            assign right_lt = cell_lt[i+1];
        end

        pns_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .head     ((i == 0) ? 1'b1 : 1'b0),
            .left_q   (left_q),
            .left_lt  (left_lt),
            .right_q  (right_q),
            .right_lt (right_lt),
            .q        (cell_q[i]),
            .lt       (cell_lt[i])
        );
    end

    pns_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .full      (buf_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_data)
    );

    assign m_tdata = {out_data.due, out_data.id};
    assign m_tuser = out_data.empty;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_CLIENTS))
        else $error("entry count beyond table size");

    a_head_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pns_pkg::ST_IDLE |-> cell_q[0].valid == (count_reg != '0))
        else $error("head cell occupancy disagrees with entry count");

    a_chain_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pns_pkg::ST_IDLE && cell_q[1].valid
        |-> cell_q[0].valid && pns_pkg::key_less(cell_q[0], cell_q[1]))
        else $error("first two cells out of order");

    a_step_reinserts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && kind == pns_pkg::KIND_STEP && count_reg != '0
        |=> state_reg == pns_pkg::ST_INSERT && ins_pop_reg)
        else $error("step on a non-empty table did not reinsert its head");

endmodule
